// ----- rtl/lrfb_pkg.sv -----
package lrfb_pkg;

  localparam int unsigned DISPLAY_WIDTH  = 128;
  localparam int unsigned DISPLAY_HEIGHT = 64;
  localparam int unsigned PAGE_COUNT     = 8;
  localparam int unsigned STORE_SIZE     = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int unsigned ADDR_W         = $clog2(STORE_SIZE);
  localparam int unsigned ERR_W          = 12;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_READ_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       pixel_on;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       done_res;
  } out_res_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] x;
    logic [7:0] y;
  } point_t;

  function automatic addr_t pix_addr(logic [4:0] page, logic [7:0] col);
    logic [17:0] full;
    full = 18'(page) * 18'(DISPLAY_WIDTH) + 18'(col);
    return full[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/lrfb_ram.sv -----
module lrfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/lrfb_walker.sv -----
module lrfb_walker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [7:0]    x0,
  input  logic [7:0]    y0,
  input  logic [7:0]    x1,
  input  logic [7:0]    y1,
  output lrfb_pkg::point_t pt
);
  import lrfb_pkg::*;

  logic                    active_r, active_nxt;
  logic [7:0]              x_r, x_nxt, y_r, y_nxt;
  logic [7:0]              xe_r, xe_nxt, ye_r, ye_nxt;
  logic [7:0]              dx_r, dx_nxt, dy_r, dy_nxt;
  logic                    sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [ERR_W:0]   e2;
  logic signed [ERR_W:0]   dx_s, dy_s;
  logic                    step_x, step_y, at_end;
  logic [7:0]              ldx, ldy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    xe_r  <= xe_nxt;
    ye_r  <= ye_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    err_r <= err_nxt;
  end

  always_comb begin
    ldx    = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    ldy    = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    dx_s   = $signed({{(ERR_W-7){1'b0}}, dx_r});
    dy_s   = $signed({{(ERR_W-7){1'b0}}, dy_r});
    e2     = {err_r, 1'b0};
    step_x = e2 > -dy_s;
    step_y = e2 < dx_s;
    at_end = (x_r == xe_r) && (y_r == ye_r);

    active_nxt = active_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    xe_nxt     = xe_r;
    ye_nxt     = ye_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    err_nxt    = err_r;

    if (load) begin
      active_nxt = 1'b1;
      x_nxt      = x0;
      y_nxt      = y0;
      xe_nxt     = x1;
      ye_nxt     = y1;
      dx_nxt     = ldx;
      dy_nxt     = ldy;
      sx_nxt     = x0 < x1;
      sy_nxt     = y0 < y1;
      err_nxt    = $signed(ERR_W'(ldx)) - $signed(ERR_W'(ldy));
    end else if (active_r) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        if (step_x) begin
          x_nxt = sx_r ? (x_r + 8'd1) : (x_r - 8'd1);
        end
        if (step_y) begin
          y_nxt = sy_r ? (y_r + 8'd1) : (y_r - 8'd1);
        end
        err_nxt = ERR_W'(err_r - (step_x ? dy_s[ERR_W-1:0] : '0)
                               + (step_y ? dx_s[ERR_W-1:0] : '0));
      end
    end

    pt.valid = active_r;
    pt.last  = at_end;
    pt.x     = x_r;
    pt.y     = y_r;
  end

endmodule

// ----- rtl/line_rasterizer_framebuffer.sv -----
// Line rasterizer over a page-layout monochrome framebuffer held in one
// synchronous RAM (one byte per column per 8-row page). After reset the block
// zeroes all STORE_SIZE bytes (1024 by default) of the RAM before it takes
// its first request. A draw-line request walks every point of the line and
// then passes through the drain and finish states to its result; the pixel
// read-modify-write is pipelined with write-to-read forwarding so the RAM
// port sustains one point per cycle. A clear request zeroes the RAM again,
// a read request fetches one byte through the read and read-wait states.
// Each request gives one result; while a finished result waits behind a
// stalled one, the block holds and takes no new request.
module line_rasterizer_framebuffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrfb_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output lrfb_pkg::out_res_t out_res
);
  import lrfb_pkg::*;

  state_t     state_r, state_nxt;
  addr_t      clr_cnt_r, clr_cnt_nxt;
  logic       clr_item_r, clr_item_nxt;
  logic       on_r, on_nxt;
  addr_t      rd_addr_r, rd_addr_nxt;
  logic       rd_ok_r, rd_ok_nxt;
  logic [7:0] res_data_r, res_data_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  addr_t      s1_addr_r, s1_addr_nxt;
  logic [2:0] s1_bit_r, s1_bit_nxt;
  logic       fwd_hit_r, fwd_hit_nxt;
  logic [7:0] fwd_data_r, fwd_data_nxt;

  logic       accept, load;
  point_t     pt;
  logic       pt_in;
  addr_t      pt_addr;
  logic [7:0] old_byte, mask;

  logic       ram_we;
  addr_t      ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  lrfb_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .x0    (in_req.x_start),
    .y0    (in_req.y_start),
    .x1    (in_req.x_end),
    .y1    (in_req.y_end),
    .pt    (pt)
  );

  lrfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_item_r  <= clr_item_nxt;
      out_valid_r <= out_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
    end
    on_r       <= on_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_data_r <= res_data_nxt;
    out_data_r <= out_data_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_bit_r   <= s1_bit_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  always_comb begin
    accept = in_valid && (state_r == ST_IDLE);
    load   = accept && (in_req.kind == KIND_DRAW);

    pt_in   = (9'(pt.x) < 9'(DISPLAY_WIDTH)) && (9'(pt.y) < 9'(DISPLAY_HEIGHT))
              && (6'(pt.y[7:3]) < 6'(PAGE_COUNT));
    pt_addr = pix_addr(pt.y[7:3], pt.x);

    old_byte = fwd_hit_r ? fwd_data_r : ram_rdata;
    mask     = 8'd1 << s1_bit_r;

    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_item_nxt  = clr_item_r;
    on_nxt        = on_r;
    rd_addr_nxt   = rd_addr_r;
    rd_ok_nxt     = rd_ok_r;
    res_data_nxt  = res_data_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    s1_valid_nxt = 1'b0;
    s1_addr_nxt  = pt_addr;
    s1_bit_nxt   = pt.y[2:0];

    ram_raddr = rd_addr_r;
    ram_we    = 1'b0;
    ram_waddr = s1_addr_r;
    ram_wdata = on_r ? (old_byte | mask) : (old_byte & ~mask);

    if (s1_valid_r) begin
      ram_we = 1'b1;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + addr_t'(1);
        if (clr_cnt_r == ADDR_W'(STORE_SIZE - 1)) begin
          clr_cnt_nxt  = '0;
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          on_nxt       = in_req.pixel_on;
          rd_addr_nxt  = pix_addr(5'(in_req.read_page), 8'(in_req.read_column));
          rd_ok_nxt    = (6'(in_req.read_page) < 6'(PAGE_COUNT))
                         && (9'(in_req.read_column) < 9'(DISPLAY_WIDTH));
          res_data_nxt = '0;
          case (in_req.kind)
            KIND_DRAW: begin
              state_nxt = ST_WALK;
            end
            KIND_CLEAR: begin
              clr_item_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            KIND_READ: begin
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_WALK: begin
        ram_raddr    = pt_addr;
        s1_valid_nxt = pt.valid && pt_in;
        if (pt.valid && pt.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_READ: begin
        state_nxt = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        res_data_nxt = rd_ok_r ? ram_rdata : '0;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    fwd_hit_nxt  = ram_we && (ram_raddr == ram_waddr);
    fwd_data_nxt = ram_wdata;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_res.read_data = out_data_r;
  assign out_res.done_res  = 1'b1;

`ifndef SYNTHESIS
  a_s1_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("pixel write outside line walk");

  a_pt_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pt.valid |-> (state_r == ST_WALK))
    else $error("walker active outside walk state");

  a_drain_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (state_r == ST_FINISH))
    else $error("drain did not lead to finish");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised without finish");
`endif

endmodule

// ----- bench/line_rasterizer_framebuffer_tb.sv -----
`timescale 1ns / 100ps

module line_rasterizer_framebuffer_tb;
  import lrfb_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 230;

  class pixel_scoreboard;
    logic [7:0] frame [STORE_SIZE];
    out_res_t expected_q[$];
    int mismatches;

    function new();
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (frame[i]) frame[i] = 8'h00;
    endfunction

    function void plot(int x, int y, bit on);
      int addr;
      logic [7:0] mask;
      if (x < 0 || y < 0 || x >= int'(DISPLAY_WIDTH) || y >= int'(DISPLAY_HEIGHT)) return;
      if ((y >> 3) >= int'(PAGE_COUNT)) return;
      addr = (y >> 3) * int'(DISPLAY_WIDTH) + x;
      mask = 8'h01 << (y & 7);
      frame[addr] = on ? (frame[addr] | mask) : (frame[addr] & ~mask);
    endfunction

    function void draw_line(int x0, int y0, int x1, int y1, bit on);
      int dx, dy, sx, sy, err, e2, x, y;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      x = x0;
      y = y0;
      for (int n = 0; n < 1024; n++) begin
        plot(x, y, on);
        if (x == x1 && y == y1) break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sy;
        end
      end
    endfunction

    function void note_request(in_req_t r);
      out_res_t res;
      res.read_data = 8'h00;
      res.done_res = 1'b1;
      case (r.kind)
        KIND_DRAW: begin
          draw_line(int'(r.x_start), int'(r.y_start), int'(r.x_end), int'(r.y_end),
                    r.pixel_on);
        end
        KIND_CLEAR: begin
          wipe();
        end
        KIND_READ: begin
          if (r.read_page < PAGE_COUNT && r.read_column < DISPLAY_WIDTH)
            res.read_data = frame[r.read_page * DISPLAY_WIDTH + r.read_column];
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected %0h got %0h", what, want, got);
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (expected_q.size() == 0) begin
        flag("unexpected result, read_data", 0, got.read_data);
        return;
      end
      want = expected_q.pop_front();
      if (got.read_data !== want.read_data) flag("read_data", want.read_data, got.read_data);
      if (got.done_res !== want.done_res) flag("done_res", want.done_res, got.done_res);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_res_t out_res;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int aim_col = 0;
  int aim_page = 0;
  pixel_scoreboard sb;

  line_rasterizer_framebuffer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_req);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_res);
  end

  always @(posedge clk) begin
    if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic in_req_t noise_request();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(in_req_t)-1:0];
  endfunction

  function automatic in_req_t make_draw(int xs, int ys, int xe, int ye, bit on);
    in_req_t r;
    r = noise_request();
    r.kind = KIND_DRAW;
    r.x_start = 8'(xs);
    r.y_start = 8'(ys);
    r.x_end = 8'(xe);
    r.y_end = 8'(ye);
    r.pixel_on = on;
    return r;
  endfunction

  function automatic in_req_t make_read(int page, int col);
    in_req_t r;
    r = noise_request();
    r.kind = KIND_READ;
    r.read_page = 3'(page);
    r.read_column = 7'(col);
    return r;
  endfunction

  function automatic in_req_t make_other(logic [1:0] code);
    in_req_t r;
    r = noise_request();
    r.kind = kind_t'(code);
    return r;
  endfunction

  function automatic in_req_t rand_request();
    in_req_t r;
    int pick, shape, mx, my;
    r = noise_request();
    pick = $urandom_range(99);
    if (pick < 46) begin
      r.kind = KIND_DRAW;
      shape = $urandom_range(99);
      if (shape < 60) begin
        r.x_start = 8'($urandom_range(127));
        r.y_start = 8'($urandom_range(63));
        r.x_end = 8'(int'(r.x_start) + $urandom_range(16) - 8);
        r.y_end = 8'(int'(r.y_start) + $urandom_range(16) - 8);
      end else if (shape < 85) begin
        r.x_start = 8'($urandom_range(127));
        r.y_start = 8'($urandom_range(63));
        r.x_end = 8'($urandom_range(127));
        r.y_end = 8'($urandom_range(63));
      end
      r.pixel_on = ($urandom_range(99) < 75);
      mx = (int'(r.x_start) + int'(r.x_end)) / 2;
      my = (int'(r.y_start) + int'(r.y_end)) / 2;
      if (mx < int'(DISPLAY_WIDTH) && my < int'(DISPLAY_HEIGHT)) begin
        aim_col = mx;
        aim_page = my >> 3;
      end
    end else if (pick < 94) begin
      r.kind = KIND_READ;
      if ($urandom_range(1)) begin
        r.read_column = 7'(aim_col + $urandom_range(2) - 1);
        r.read_page = 3'(aim_page);
      end
    end else if (pick < 97) begin
      r.kind = KIND_CLEAR;
    end else begin
      r.kind = kind_t'(KIND_SPARE);
    end
    return r;
  endfunction

  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_req(make_draw(0, 0, 0, 0, 1'b1));
    send_req(make_read(0, 0));
    send_req(make_draw(255, 255, 255, 255, 1'b1));
    send_req(make_draw(0, 0, 127, 63, 1'b1));
    send_req(make_read(7, 127));
    send_req(make_draw(127, 0, 0, 63, 1'b1));
    send_req(make_draw(0, 7, 255, 7, 1'b1));
    send_req(make_read(0, 64));
    send_req(make_draw(5, 255, 5, 0, 1'b1));
    send_req(make_read(3, 5));
    send_req(make_draw(200, 100, 10, 20, 1'b1));
    send_req(make_draw(0, 63, 127, 63, 1'b0));
    send_req(make_read(7, 50));
    send_req(make_draw(255, 0, 0, 255, 1'b1));
    send_req(make_read(4, 60));
    send_req(make_other(KIND_SPARE));
    send_req(make_read(0, 127));
    send_req(make_other(KIND_CLEAR));
    send_req(make_read(0, 0));
    send_req(make_read(7, 127));
    send_req(make_draw(100, 40, 3, 45, 1'b1));
    send_req(make_read(5, 50));
    send_req(make_draw(128, 64, 128, 64, 1'b1));
    send_req(make_draw(100, 40, 100, 40, 1'b0));
    send_req(make_read(5, 100));
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin send_idle_pct = 88; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 88; end
        3: begin send_idle_pct = 8; stall_pct = 8; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_req(rand_request());
      wait_idle();
    end

    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
